### design/glb_pkg.sv
package glb_pkg;

	localparam int PIX_W = 8;
	localparam int MAX_OUT = 17;
	localparam int CNT_W = $clog2(MAX_OUT + 1);

	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	typedef logic [PIX_W-1:0] chan_t;
	typedef chan_t [2:0] rgb_t;

	// exp(-pi*(0.133*i)^2) in Q1.16, rounded to nearest; zero past the table
	function automatic logic [16:0] gauss_q16(input logic [4:0] idx);
		logic [16:0] w;
		begin
			unique case (idx)
				5'd0: w = 17'd65536;
				5'd1: w = 17'd61993;
				5'd2: w = 17'd52474;
				5'd3: w = 17'd39744;
				5'd4: w = 17'd26936;
				5'd5: w = 17'd16335;
				5'd6: w = 17'd8864;
				5'd7: w = 17'd4304;
				5'd8: w = 17'd1870;
				5'd9: w = 17'd727;
				5'd10: w = 17'd253;
				5'd11: w = 17'd79;
				5'd12: w = 17'd22;
				5'd13: w = 17'd5;
				5'd14: w = 17'd1;
				default: w = 17'd0;
			endcase
			return w;
		end
	endfunction

endpackage

### design/glb_div.sv
module glb_div #(
	parameter int AW = 34,
	parameter int SW = 26
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0][AW-1:0]    dividend,
	input  logic [SW-1:0]         divisor,
	output logic                  done,
	output glb_pkg::rgb_t         quot
);
	import glb_pkg::*;

	localparam int QCW = $clog2(PIX_W);

	logic [2:0][AW-1:0] rem_q;
	logic [AW-1:0]      dv_q;
	logic [QCW-1:0]     cnt_q;
	logic               run_q;
	logic               done_q;
	rgb_t               quot_q;

	// restoring division, one quotient bit per cycle on all three channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= QCW'(PIX_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0)
					run_q <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dv_q <= AW'(divisor) << (PIX_W - 1);
		end else if (run_q) begin
			for (int c = 0; c < 3; c++) begin
				if (rem_q[c] >= dv_q) begin
					rem_q[c] <= rem_q[c] - dv_q;
					quot_q[c] <= {quot_q[c][PIX_W-2:0], 1'b1};
				end else begin
					quot_q[c] <= {quot_q[c][PIX_W-2:0], 1'b0};
				end
			end
			dv_q <= dv_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### design/gaussian_line_blur_top.sv
// Horizontal Gaussian blur of one RGB line.
//
// Pixels enter on the input channel (in_valid/in_ready, red_in/green_in/
// blue_in) in line order. Blurred pixels leave on the output channel
// (out_valid/out_ready, red_out/green_out/blue_out, line_end). Output o is
// released once pixel o+radius has arrived; the last pixel of a line
// (position line_length-1) flushes every pending output, at most 17 per
// input, and line_end flags the final one.
//
// One multiply-accumulate unit walks the taps of one output, one tap per
// cycle from the window memory, then a shared restoring divider produces
// 8 quotient bits and a done flag; taps outside the line are skipped.
// An input transfer is done only once each output it releases has been
// computed and emitted; in_ready is high only while the sequencer is idle.
//
// The result register holds one finished pixel; while the receiver stalls
// the sequencer waits to load the next one and takes no new input.
// Reset clears the line position and the output valid flag; the window
// memory is not cleared. Registers: blur_radius at 0x0, line_length at 0x4.
module gaussian_line_blur_top #(
	parameter int MAX_RADIUS = 16,
	parameter int MAX_LINE = 4096,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready,
	input  logic       in_valid,
	output logic       in_ready,
	input  glb_pkg::chan_t red_in,
	input  glb_pkg::chan_t green_in,
	input  glb_pkg::chan_t blue_in,
	output logic       out_valid,
	input  logic       out_ready,
	output glb_pkg::chan_t red_out,
	output glb_pkg::chan_t green_out,
	output glb_pkg::chan_t blue_out,
	output logic       line_end
);
	import glb_pkg::*;

	localparam int DEPTH = 2 * MAX_RADIUS + 1;
	localparam int SLW = $clog2(DEPTH);
	localparam int PW = $clog2(MAX_LINE);
	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int WD = WEIGHT_FRAC_BITS + 1;
	localparam int SW = WD + SLW;
	localparam int AW = SW + PIX_W;
	localparam int EW = (PW + 1 > 13) ? PW + 1 : 13;
	localparam int SUP = (WEIGHT_FRAC_BITS >= 16) ? WEIGHT_FRAC_BITS - 16 : 0;
	localparam int SDN = (WEIGHT_FRAC_BITS < 16) ? 16 - WEIGHT_FRAC_BITS : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_TAP = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	function automatic logic [WD-1:0] weight_of(input logic [4:0] idx);
		logic [40:0] v;
		begin
			v = 41'(gauss_q16(idx));
			if (WEIGHT_FRAC_BITS >= 16)
				v = v << SUP;
			else
				v = (v + (41'd1 << (SDN - 1))) >> SDN;
			return WD'(v);
		end
	endfunction

	// configuration
	logic [4:0]  blur_radius_q;
	logic [12:0] line_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_radius_q <= 5'd1;
			line_length_q <= 13'd640;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_RADIUS: blur_radius_q <= pwdata[4:0];
				REG_LENGTH: line_length_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RADIUS: prdata = {27'd0, blur_radius_q};
			REG_LENGTH: prdata = {19'd0, line_length_q};
			default: prdata = '0;
		endcase
	end
	assign pready = 1'b1;

	// clamp the registers to their usable ranges
	logic [RW-1:0] r_eff;
	logic [EW-1:0] len_eff;

	always_comb begin
		priority if (blur_radius_q == 5'd0)
			r_eff = RW'(1);
		else if (blur_radius_q > 5'(MAX_RADIUS))
			r_eff = RW'(MAX_RADIUS);
		else
			r_eff = RW'(blur_radius_q);
		priority if (line_length_q == 13'd0)
			len_eff = EW'(1);
		else if (EW'(line_length_q) > EW'(MAX_LINE))
			len_eff = EW'(MAX_LINE);
		else
			len_eff = EW'(line_length_q);
	end

	// sequencer state
	logic [2:0]      state_q;
	logic [PW-1:0]   pos_q;
	logic [SLW-1:0]  wp_q;
	logic [PW:0]     o_q;
	logic [SLW-1:0]  os_q;
	logic [CNT_W-1:0] n_q;
	logic            is_end_q;
	logic [PW:0]     j_q;
	logic [PW:0]     jhi_q;
	logic [SLW-1:0]  sl_q;
	logic            rd_v_q;
	logic [WD-1:0]   rd_w_q;
	logic [2:0][AW-1:0] acc_q;
	logic [SW-1:0]   wsum_q;

	logic [23:0]     win_mem [DEPTH];
	logic [23:0]     rd_q;

	logic            in_xfer;
	logic            out_free;
	logic            go;
	logic            issue;
	logic            div_start;
	logic            div_done;
	rgb_t            div_quot;
	logic [PW:0]     p_x;
	logic [PW:0]     r_x;
	logic [PW:0]     jlo;
	logic [PW:0]     reach;
	logic [PW:0]     back_span;
	logic [SLW:0]    sl_start;
	logic [PW:0]     tap_d;
	logic [PW:0]     tap_abs;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign p_x = {1'b0, pos_q};
	assign r_x = (PW + 1)'(r_eff);
	assign reach = o_q + r_x;
	assign go = (n_q < CNT_W'(MAX_OUT)) && (is_end_q ? (o_q <= p_x) : (reach <= p_x));
	assign jlo = (o_q >= r_x) ? o_q - r_x : '0;
	assign back_span = o_q - jlo;
	assign sl_start = {1'b0, os_q} - (SLW + 1)'(back_span);
	assign issue = (j_q <= jhi_q);
	assign tap_d = j_q - o_q;
	assign tap_abs = tap_d[PW] ? -tap_d : tap_d;
	assign div_start = (state_q == ST_TAP) && !issue && !rd_v_q;

	// window memory: written on input transfer, read one tap per cycle
	always_ff @(posedge clk) begin
		if (in_xfer)
			win_mem[wp_q] <= {red_in, green_in, blue_in};
		rd_q <= win_mem[sl_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			wp_q <= '0;
			o_q <= '0;
			os_q <= '0;
			n_q <= '0;
			is_end_q <= 1'b0;
			rd_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						is_end_q <= (EW'(pos_q) + EW'(1)) >= len_eff;
						n_q <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (go) begin
						state_q <= ST_TAP;
					end else begin
						// done with this input: advance or wrap the line
						if (is_end_q) begin
							pos_q <= '0;
							wp_q <= '0;
							o_q <= '0;
							os_q <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
							wp_q <= (wp_q == SLW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TAP: begin
					rd_v_q <= issue;
					if (!issue && !rd_v_q)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						n_q <= n_q + 1'b1;
						o_q <= o_q + 1'b1;
						os_q <= (os_q == SLW'(DEPTH - 1)) ? '0 : os_q + 1'b1;
						state_q <= ST_CHECK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// tap walk and multiply-accumulate
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			j_q <= jlo;
			jhi_q <= (reach < p_x) ? reach : p_x;
			sl_q <= sl_start[SLW] ? SLW'(sl_start + (SLW + 1)'(DEPTH)) : SLW'(sl_start);
			acc_q <= '0;
			wsum_q <= '0;
		end else if (state_q == ST_TAP) begin
			if (issue) begin
				rd_w_q <= weight_of(5'(tap_abs));
				j_q <= j_q + 1'b1;
				sl_q <= (sl_q == SLW'(DEPTH - 1)) ? '0 : sl_q + 1'b1;
			end
			if (rd_v_q) begin
				for (int c = 0; c < 3; c++)
					acc_q[c] <= acc_q[c] + AW'(rd_w_q * rd_q[8*c +: 8]);
				wsum_q <= wsum_q + SW'(rd_w_q);
			end
		end
	end

	glb_div #(
		.AW(AW),
		.SW(SW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(acc_q),
		.divisor(wsum_q),
		.done(div_done),
		.quot(div_quot)
	);

	// result register
	logic out_valid_q;
	rgb_t out_pix_q;
	logic line_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_pix_q <= div_quot;
			line_end_q <= is_end_q && ((o_q == p_x) || (n_q == CNT_W'(MAX_OUT - 1)));
		end
	end

	assign out_valid = out_valid_q;
	// accumulator lanes: 0 = blue, 1 = green, 2 = red
	assign red_out = out_pix_q[2];
	assign green_out = out_pix_q[1];
	assign blue_out = out_pix_q[0];
	assign line_end = line_end_q;

	// the center tap is always in range, so the divisor is never zero
	a_wsum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (wsum_q != '0))
		else $error("zero weight sum at divide");

	// only outputs whose center pixel has arrived are computed
	a_center_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAP) |-> (o_q <= p_x))
		else $error("output ahead of input");

	a_out_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q <= CNT_W'(MAX_OUT)))
		else $error("too many outputs for one input");

	// no input is taken while a divide is running
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> !$past(in_xfer))
		else $error("input accepted while busy");

endmodule
